/* hw/rtl/dic_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dic_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned CountWidth        = 9;
  localparam int unsigned ValueWidth        = 32;

  localparam logic KindFirst  = 1'b0;
  localparam logic KindSecond = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [ValueWidth-1:0]  value;
    logic                          last;
  } in_word_t;

  typedef struct packed {
    logic [CountWidth-1:0] common_count;
    logic                  overflow;
  } out_word_t;

  // One word travelling down the chain of cells.
  typedef struct packed {
    logic                          valid;
    logic                          kind;
    logic signed [ValueWidth-1:0]  value;
    logic                          last;
    logic                          found;
    logic                          new_match;
  } chain_word_t;

endpackage

`default_nettype wire

/* hw/rtl/dic_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module dic_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire dic_pkg::chain_word_t item_i,
  output dic_pkg::chain_word_t      item_o
);

  logic                                  used_q, used_d;
  logic                                  first_q, first_d;
  logic                                  second_q, second_d;
  logic signed [dic_pkg::ValueWidth-1:0] value_q, value_d;
  dic_pkg::chain_word_t                  item_q, item_d;

  logic hit;
  logic claim;
  logic first_set;
  logic second_set;
  logic both_new;

  always_comb begin
    hit        = item_i.valid && !item_i.found && used_q && (item_i.value == value_q);
    claim      = item_i.valid && !item_i.found && !used_q;
    first_set  = (hit || claim) && (item_i.kind == dic_pkg::KindFirst);
    second_set = (hit || claim) && (item_i.kind == dic_pkg::KindSecond);

    first_d  = claim ? first_set  : (first_q  || first_set);
    second_d = claim ? second_set : (second_q || second_set);
    both_new = hit && !(first_q && second_q) && first_d && second_d;
    used_d   = used_q || claim;
    value_d  = claim ? item_i.value : value_q;

    item_d           = item_i;
    item_d.found     = item_i.found || hit || claim;
    item_d.new_match = item_i.new_match || both_new;

    // The final word of a data set empties the cell once it has passed.
    if (item_i.valid && item_i.last) begin
      used_d   = 1'b0;
      first_d  = 1'b0;
      second_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      first_q  <= 1'b0;
      second_q <= 1'b0;
      item_q   <= '0;
    end else if (en_i) begin
      used_q   <= used_d;
      first_q  <= first_d;
      second_q <= second_d;
      item_q   <= item_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

/* hw/rtl/dic_tail.sv */
`timescale 1ns / 1ps
`default_nettype none

module dic_tail #(
  parameter int unsigned TABLE_DEPTH = dic_pkg::TableDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire dic_pkg::chain_word_t item_i,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output dic_pkg::out_word_t        out_word_o
);

  localparam logic [dic_pkg::CountWidth-1:0] CountMax = '1;
  localparam int unsigned CountBound =
    (TABLE_DEPTH < (2 ** dic_pkg::CountWidth) - 1) ? TABLE_DEPTH
                                                   : (2 ** dic_pkg::CountWidth) - 1;

  logic [dic_pkg::CountWidth-1:0] count_q, count_d;
  logic                           drop_q, drop_d;
  logic                           out_valid_q, out_valid_d;
  dic_pkg::out_word_t             out_word_q, out_word_d;

  always_comb begin
    count_d     = count_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    if (en_i && item_i.valid) begin
      if (item_i.new_match && (count_q != CountMax)) begin
        count_d = count_q + 1'b1;
      end
      drop_d = drop_q || !item_i.found;
      if (item_i.last) begin
        out_valid_d             = 1'b1;
        out_word_d.common_count = count_d;
        out_word_d.overflow     = drop_d;
        count_d                 = '0;
        drop_d                  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_rise_needs_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(en_i && item_i.valid && item_i.last))
    else $error("result appeared without a final word");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(out_word_q.common_count) <= CountBound))
    else $error("common count exceeds the table bound");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && item_i.valid && item_i.last) |=> (count_q == '0 && !drop_q))
    else $error("running totals not cleared after a final word");

endmodule

`default_nettype wire

/* hw/rtl/distinct_intersection_counter_top.sv */
// A result is registered in the tail once its final word has passed every cell of the chain.
// Throughput: one word per cycle unless stalled; a word walks one cell per cycle.
// The chain stalls only while a new result meets an output register still held.
// Reset is asynchronous and active low; it empties every cell and the totals.
// A final word empties each cell as it passes, so the next data set may follow at once.
`timescale 1ns / 1ps
`default_nettype none

module distinct_intersection_counter_top #(
  parameter int unsigned TABLE_DEPTH = dic_pkg::TableDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire dic_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dic_pkg::out_word_t     out_word_o
);

  dic_pkg::chain_word_t chain [TABLE_DEPTH+1];
  logic                 en;
  logic                 emit_pending;

  assign emit_pending = chain[TABLE_DEPTH].valid && chain[TABLE_DEPTH].last;
  assign en           = !(out_valid_o && out_stall_i && emit_pending);
  assign in_stall_o   = !en;

  always_comb begin
    chain[0].valid     = in_valid_i && en;
    chain[0].kind      = in_word_i.kind;
    chain[0].value     = in_word_i.value;
    chain[0].last      = in_word_i.last;
    chain[0].found     = 1'b0;
    chain[0].new_match = 1'b0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  dic_tail #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .item_i      (chain[TABLE_DEPTH]),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && emit_pending))
    else $error("input stalled without a blocked result");

  a_held_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("held result dropped");

  a_chain_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(chain[TABLE_DEPTH]))
    else $error("chain moved while stalled");

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TableDepth  = dic_pkg::TableDepthDefault;
  localparam int unsigned CountMax    = (1 << dic_pkg::CountWidth) - 1;
  localparam int          RandomItems = 320;
  localparam int          LongHold    = 700;
  localparam int          IdleLimit   = 4000;
  localparam logic signed [dic_pkg::ValueWidth-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [dic_pkg::ValueWidth-1:0] ValMax = 32'sh7FFF_FFFF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  dic_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  dic_pkg::out_word_t out_word_o;

  distinct_intersection_counter_top #(
    .TABLE_DEPTH(TableDepth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Model of the value table.
  logic [dic_pkg::ValueWidth-1:0] stored_vals [TableDepth];
  bit                             in_first   [TableDepth];
  bit                             in_second  [TableDepth];
  int unsigned                    fill_count;
  int unsigned                    match_count;
  bit                             value_dropped;

  dic_pkg::out_word_t expected_counts [$];

  int  errors = 0;
  int  results_checked = 0;
  int  sets_sent = 0;
  int  overflow_sets = 0;
  int  largest_count = 0;
  int  random_items = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  bit  hold_toggle = 1'b0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic predict_word(input dic_pkg::in_word_t w);
    int                 idx;
    bit                 had_both;
    dic_pkg::out_word_t res;
    idx = -1;
    for (int k = 0; k < fill_count; k++) begin
      if (idx < 0 && stored_vals[k] == w.value) begin
        idx = k;
      end
    end
    if (idx < 0 && fill_count < TableDepth) begin
      idx = fill_count;
      stored_vals[idx] = w.value;
      in_first[idx] = 1'b0;
      in_second[idx] = 1'b0;
      fill_count++;
    end else if (idx < 0) begin
      value_dropped = 1'b1;
    end
    if (idx >= 0) begin
      had_both = in_first[idx] && in_second[idx];
      if (w.kind == dic_pkg::KindFirst) begin
        in_first[idx] = 1'b1;
      end else begin
        in_second[idx] = 1'b1;
      end
      if (!had_both && in_first[idx] && in_second[idx] && match_count < CountMax) begin
        match_count++;
      end
    end
    if (w.last) begin
      res.common_count = match_count[dic_pkg::CountWidth-1:0];
      res.overflow = value_dropped;
      expected_counts.push_back(res);
      sets_sent++;
      if (value_dropped) begin
        overflow_sets++;
      end
      if (match_count > largest_count) begin
        largest_count = match_count;
      end
      fill_count = 0;
      match_count = 0;
      value_dropped = 1'b0;
    end
  endtask

  // Called at a rising edge; returns at the edge that accepts the word or ends its gap.
  task automatic send_word(input logic kind, input logic [dic_pkg::ValueWidth-1:0] value,
                           input logic last);
    dic_pkg::in_word_t w;
    int                gap;
    w.kind = kind;
    w.value = value;
    w.last = last;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_word(w);
    gap = 0;
    if (!tx_steady && $urandom_range(0, 99) < 30) begin
      gap = rand_gap();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [dic_pkg::ValueWidth-1:0] pick_pool_value(
    input logic [dic_pkg::ValueWidth-1:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return ValMin;
        1: return ValMax;
        2: return '0;
        default: return '1;
      endcase
    end
    if (r < 55) begin
      return base + $urandom_range(0, 15);
    end
    return $urandom;
  endfunction

  task automatic send_random_set();
    logic [dic_pkg::ValueWidth-1:0] pool [512];
    logic [dic_pkg::ValueWidth-1:0] base;
    int n;
    int pool_n;
    bit wide;
    base = $urandom;
    wide = ($urandom_range(0, 99) < 3);
    if (wide) begin
      pool_n = $urandom_range(250, 280);
      n = pool_n + $urandom_range(0, 20);
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      pool_n = $urandom_range(1, n);
    end
    for (int i = 0; i < pool_n; i++) begin
      pool[i] = wide ? $urandom : pick_pool_value(base);
    end
    tx_steady = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n; i++) begin
      send_word(1'($urandom_range(0, 1)),
                (wide && i < pool_n) ? pool[i] : pool[$urandom_range(0, pool_n - 1)],
                i == n - 1);
      random_items++;
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_directed_edges();
    send_word(dic_pkg::KindFirst, ValMin, 1'b0);
    send_word(dic_pkg::KindFirst, ValMax, 1'b0);
    send_word(dic_pkg::KindFirst, 32'h0000_0000, 1'b0);
    send_word(dic_pkg::KindFirst, 32'hFFFF_FFFF, 1'b0);
    send_word(dic_pkg::KindSecond, 32'hFFFF_FFFF, 1'b0);
    send_word(dic_pkg::KindSecond, ValMin, 1'b0);
    send_word(dic_pkg::KindSecond, 32'h0000_0001, 1'b0);
    send_word(dic_pkg::KindFirst, 32'h0000_0000, 1'b0);
    send_word(dic_pkg::KindSecond, 32'h8000_0001, 1'b0);
    send_word(dic_pkg::KindSecond, ValMax, 1'b1);
    send_word(dic_pkg::KindSecond, 32'h1234_5678, 1'b1);
    // The final word itself completes the only match.
    send_word(dic_pkg::KindFirst, 32'h0000_0007, 1'b0);
    send_word(dic_pkg::KindFirst, 32'h0000_0007, 1'b0);
    send_word(dic_pkg::KindSecond, 32'h0000_0007, 1'b1);
    send_word(dic_pkg::KindSecond, 32'h0000_0009, 1'b0);
    send_word(dic_pkg::KindFirst, 32'h0000_0009, 1'b0);
    send_word(dic_pkg::KindFirst, 32'h0000_0009, 1'b1);
    send_word(dic_pkg::KindFirst, 32'h4000_0000, 1'b0);
    send_word(dic_pkg::KindSecond, 32'hC000_0000, 1'b1);
    wait_for_results();
  endtask

  task automatic test_table_full();
    logic [dic_pkg::ValueWidth-1:0] base;
    logic [dic_pkg::ValueWidth-1:0] step;
    base = $urandom;
    step = $urandom | 32'h1;
    tx_steady = 1'b1;
    for (int i = 0; i < TableDepth; i++) begin
      send_word(dic_pkg::KindFirst, base + i * step, 1'b0);
    end
    tx_steady = 1'b0;
    for (int i = 0; i < TableDepth - 1; i++) begin
      send_word(dic_pkg::KindSecond, base + i * step, 1'b0);
    end
    send_word(dic_pkg::KindSecond, base + TableDepth * step, 1'b0);
    // Stored entries must still gain flags after a value has been dropped.
    send_word(dic_pkg::KindSecond, base + (TableDepth - 1) * step, 1'b0);
    send_word(dic_pkg::KindFirst, base, 1'b0);
    send_word(dic_pkg::KindFirst, base + (TableDepth + 1) * step, 1'b1);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    hold_toggle <= ~hold_toggle;
    tx_steady = 1'b1;
    for (int i = 0; i < 300; i++) begin
      send_word(1'($urandom_range(0, 1)), $urandom, 1'b1);
    end
    tx_steady = 1'b0;
    wait_for_results();
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) begin
      send_random_set();
    end
    wait_for_results();
    for (int i = 0; i < 3; i++) begin
      send_random_set();
    end
  endtask

  task automatic test_random_sets();
    random_items = 0;
    while (random_items < RandomItems) begin
      send_random_set();
    end
  endtask

  // Receiver: random stalls, steady stretches and one long hold on request.
  always @(posedge clk_i) begin
    int  stall_left;
    int  hold_left;
    bit  hold_seen;
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LongHold - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_steady) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = rand_gap() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    if ($urandom_range(0, 499) == 0) begin
      rx_steady = ~rx_steady;
    end
  end

  always @(posedge clk_i) begin
    dic_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected word, expected none, got count %0d overflow %0b",
                 $time, out_word_o.common_count, out_word_o.overflow);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (out_word_o.common_count !== want.common_count) begin
          $display("%0t: common_count mismatch, expected %0d, got %0d",
                   $time, want.common_count, out_word_o.common_count);
          errors++;
        end
        if (out_word_o.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch, expected %0b, got %0b",
                   $time, want.overflow, out_word_o.overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    int idle_cycles;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no progress for %0d cycles, %0d words outstanding",
               $time, IdleLimit, expected_counts.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    fill_count = 0;
    match_count = 0;
    value_dropped = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_table_full();
    test_output_backpressure();
    test_drain_pause();
    test_random_sets();
    wait_for_results();
    repeat (TableDepth + 20) @(posedge clk_i);
    $display("Sent %0d data sets and checked %0d result words.", sets_sent, results_checked);
    $display("Overflowed sets: %0d, largest common count: %0d.", overflow_sets, largest_count);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
